>>> rtl/core/iia_pkg.sv
// Shared types and codes for the iterative integer ALU.
package iia_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int REQ_W          = 3;
  localparam int ST_W           = 2;

  // Operation codes
  localparam logic [REQ_W-1:0] OP_ADD = 3'd0;
  localparam logic [REQ_W-1:0] OP_SUB = 3'd1;
  localparam logic [REQ_W-1:0] OP_MUL = 3'd2;
  localparam logic [REQ_W-1:0] OP_DIV = 3'd3;
  localparam logic [REQ_W-1:0] OP_POW = 3'd4;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_DIV_ZERO = 2'd1;
  localparam logic [ST_W-1:0] ST_NEG_DIV  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_MUL,
    S_MUL_WB,
    S_DIV,
    S_DIV_WB,
    S_POW_CHECK,
    S_POW_ACC_LD,
    S_POW_ACC_MUL,
    S_POW_ACC_WB,
    S_POW_SQ_LD,
    S_POW_SQ_MUL,
    S_POW_SQ_WB,
    S_POW_WB,
    S_DONE
  } iia_state_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_DISPATCH,
    CMD_MUL_STEP,
    CMD_MUL_WB,
    CMD_DIV_STEP,
    CMD_DIV_WB,
    CMD_POW_LD_ACC,
    CMD_POW_LD_SQ,
    CMD_POW_WB_ACC,
    CMD_POW_WB_SQ,
    CMD_POW_WB
  } iia_cmd_t;

  // Status of the datapath as seen by the sequencer
  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             a_zero;
    logic             a_neg;
    logic             b_zero;
    logic             b_neg;
    logic             mul_last;
    logic             expo_zero;
    logic             expo_bit0;
    logic             expo_upper_zero;
  } iia_flags_t;

endpackage

>>> rtl/core/iterative_integer_alu.sv
// Iterative integer ALU (add, subtract, multiply, divide, power) with stream ports.
// One word in, one word out. Every operation runs through a single shared
// DATA_WIDTH-bit adder stepped by a sequencer, and the block takes no new word
// until the current one has been handed to the output register. Add, subtract,
// unused codes and every special case finish at dispatch; multiply runs one
// shift-add step per bit of the multiplier; divide runs one restoring step
// per bit of DATA_WIDTH; power runs a square-and-multiply loop in which
// each product is a shift-add of up to DATA_WIDTH steps, with a load before
// it and a write-back after it. A finished result may wait in the output
// register while the next word is accepted.
module iterative_integer_alu #(
  parameter int DATA_WIDTH = iia_pkg::DATA_WIDTH_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      s_tvalid,
  output logic                                      s_tready,
  // operand_a, operand_b, zero padding
  input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]         s_tdata,
  // req_type
  input  logic [iia_pkg::REQ_W-1:0]                 s_tuser,
  output logic                                      m_tvalid,
  input  logic                                      m_tready,
  // result_value, remainder_value, zero padding
  output logic [((2*DATA_WIDTH+7)/8)*8-1:0]         m_tdata,
  // status_code
  output logic [iia_pkg::ST_W-1:0]                  m_tuser
);
  import iia_pkg::*;

  localparam int TDATA_W = ((2*DATA_WIDTH+7)/8)*8;

  iia_cmd_t              cmd;
  iia_flags_t            flags;
  logic                  res_valid;
  logic                  out_free;
  logic                  cap;
  logic [DATA_WIDTH-1:0] res_value;
  logic [DATA_WIDTH-1:0] rem_value;
  logic [ST_W-1:0]       status;
  logic [DATA_WIDTH-1:0] out_res;
  logic [DATA_WIDTH-1:0] out_rem;
  logic [ST_W-1:0]       out_st;

  assign out_free = !m_tvalid || m_tready;
  assign cap      = res_valid && out_free;

  iia_seq #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .out_free  (out_free),
    .flags     (flags),
    .cmd       (cmd),
    .in_ready  (s_tready),
    .res_valid (res_valid)
  );

  iia_unit #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_unit (
    .clk       (clk),
    .cmd       (cmd),
    .in_req    (s_tuser),
    .in_a      (s_tdata[DATA_WIDTH-1:0]),
    .in_b      (s_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
    .flags     (flags),
    .res_value (res_value),
    .rem_value (rem_value),
    .status    (status)
  );

  // Output register: hold the word until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cap) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cap) begin
      out_res <= res_value;
      out_rem <= rem_value;
      out_st  <= status;
    end
  end

  assign m_tdata = TDATA_W'({out_rem, out_res});
  assign m_tuser = out_st;

  // An error word carries no quotient and no remainder
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != ST_OK)) |-> (m_tdata == '0))
    else $error("error status with nonzero data");

  // Busy after accepting a word
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("ready held after accept");

  // No result can be captured the cycle after acceptance
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !cap)
    else $error("result captured before dispatch");

endmodule

>>> rtl/core/iia_unit.sv
// Datapath of the iterative integer ALU: operand registers and one shared adder.
module iia_unit #(
  parameter int DATA_WIDTH = iia_pkg::DATA_WIDTH_DEF
) (
  input  logic                        clk,
  input  iia_pkg::iia_cmd_t           cmd,
  input  logic [iia_pkg::REQ_W-1:0]   in_req,
  input  logic [DATA_WIDTH-1:0]       in_a,
  input  logic [DATA_WIDTH-1:0]       in_b,
  output iia_pkg::iia_flags_t         flags,
  output logic [DATA_WIDTH-1:0]       res_value,
  output logic [DATA_WIDTH-1:0]       rem_value,
  output logic [iia_pkg::ST_W-1:0]    status
);
  import iia_pkg::*;

  localparam int W = DATA_WIDTH;

  logic [REQ_W-1:0] req;
  logic [W-1:0]     ra;
  logic [W-1:0]     rb;
  logic [W-1:0]     mx;
  logic [W-1:0]     my;
  logic [W-1:0]     mp;
  logic [W-1:0]     quo;
  logic [W-1:0]     rem;
  logic [W-1:0]     acc;
  logic [W-1:0]     sq;
  logic [W-1:0]     expo;

  logic [W-1:0] add_x;
  logic [W-1:0] add_y;
  logic         add_sub;
  logic [W:0]   sum;
  logic [W-1:0] div_shift;

  // Partial remainder stays below the divisor, so its top bit is free
  assign div_shift = {rem[W-2:0], quo[W-1]};

  always_comb begin
    add_x   = ra;
    add_y   = rb;
    add_sub = 1'b0;
    case (cmd)
      CMD_DISPATCH: begin
        add_sub = (req == OP_SUB);
      end
      CMD_MUL_STEP: begin
        add_x = mp;
        add_y = mx;
      end
      CMD_DIV_STEP: begin
        add_x   = div_shift;
        add_sub = 1'b1;
      end
      default: ;
    endcase
  end

  assign sum = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)} + {{W{1'b0}}, add_sub};

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        req <= in_req;
        ra  <= in_a;
        rb  <= in_b;
      end
      CMD_DISPATCH: begin
        res_value <= '0;
        rem_value <= '0;
        status    <= ST_OK;
        mx        <= ra;
        my        <= rb;
        mp        <= '0;
        quo       <= ra;
        rem       <= '0;
        acc       <= W'(1);
        sq        <= ra;
        expo      <= rb;
        case (req) inside
          OP_ADD, OP_SUB: res_value <= sum[W-1:0];
          OP_DIV: begin
            if (rb == '0) begin
              status <= ST_DIV_ZERO;
            end else if (rb[W-1]) begin
              status <= ST_NEG_DIV;
            end else if (ra[W-1]) begin
              rem_value <= ra;
            end
          end
          OP_POW: begin
            if (rb == '0) begin
              res_value <= (ra == '0) ? '0 : W'(1);
            end else if (rb[W-1]) begin
              res_value <= ra;
            end
          end
          default: ;
        endcase
      end
      CMD_MUL_STEP: begin
        if (my[0]) begin
          mp <= sum[W-1:0];
        end
        mx <= {mx[W-2:0], 1'b0};
        my <= {1'b0, my[W-1:1]};
      end
      CMD_MUL_WB: res_value <= mp;
      CMD_DIV_STEP: begin
        if (sum[W]) begin
          rem <= sum[W-1:0];
          quo <= {quo[W-2:0], 1'b1};
        end else begin
          rem <= div_shift;
          quo <= {quo[W-2:0], 1'b0};
        end
      end
      CMD_DIV_WB: begin
        res_value <= quo;
        rem_value <= rem;
      end
      CMD_POW_LD_ACC: begin
        mx <= acc;
        my <= sq;
        mp <= '0;
      end
      CMD_POW_LD_SQ: begin
        mx <= sq;
        my <= sq;
        mp <= '0;
      end
      CMD_POW_WB_ACC: acc <= mp;
      CMD_POW_WB_SQ: begin
        sq   <= mp;
        expo <= {1'b0, expo[W-1:1]};
      end
      CMD_POW_WB: res_value <= acc;
      default: ;
    endcase
  end

  always_comb begin
    flags.req             = req;
    flags.a_zero          = (ra == '0);
    flags.a_neg           = ra[W-1];
    flags.b_zero          = (rb == '0);
    flags.b_neg           = rb[W-1];
    flags.mul_last        = (my[W-1:1] == '0);
    flags.expo_zero       = (expo == '0);
    flags.expo_bit0       = expo[0];
    flags.expo_upper_zero = (expo[W-1:1] == '0);
  end

endmodule

>>> rtl/core/iia_seq.sv
// Sequencer of the iterative integer ALU: steps the shared datapath per operation.
module iia_seq #(
  parameter int DATA_WIDTH = iia_pkg::DATA_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                out_free,
  input  iia_pkg::iia_flags_t flags,
  output iia_pkg::iia_cmd_t   cmd,
  output logic                in_ready,
  output logic                res_valid
);
  import iia_pkg::*;

  localparam int CNT_W = $clog2(DATA_WIDTH);

  iia_state_t       state;
  iia_state_t       state_next;
  logic [CNT_W-1:0] cnt;
  logic             div_last;

  assign div_last = (cnt == CNT_W'(DATA_WIDTH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == S_DIV) begin
        cnt <= cnt + CNT_W'(1);
      end else begin
        cnt <= '0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (flags.req)
          OP_MUL: state_next = (flags.b_zero || flags.b_neg) ? S_DONE : S_MUL;
          OP_DIV: state_next = (flags.b_zero || flags.b_neg || flags.a_neg) ? S_DONE : S_DIV;
          OP_POW: state_next = (flags.b_zero || flags.b_neg || flags.a_zero) ?
                               S_DONE : S_POW_CHECK;
          default: state_next = S_DONE;
        endcase
      end
      S_MUL: begin
        if (flags.mul_last) state_next = S_MUL_WB;
      end
      S_MUL_WB: state_next = S_DONE;
      S_DIV: begin
        if (div_last) state_next = S_DIV_WB;
      end
      S_DIV_WB: state_next = S_DONE;
      S_POW_CHECK: begin
        if (flags.expo_zero) begin
          state_next = S_POW_WB;
        end else if (flags.expo_bit0) begin
          state_next = S_POW_ACC_LD;
        end else begin
          state_next = S_POW_SQ_LD;
        end
      end
      S_POW_ACC_LD: state_next = S_POW_ACC_MUL;
      S_POW_ACC_MUL: begin
        if (flags.mul_last) state_next = S_POW_ACC_WB;
      end
      // skip the last squaring: its value is never used
      S_POW_ACC_WB: state_next = flags.expo_upper_zero ? S_POW_SQ_WB : S_POW_SQ_LD;
      S_POW_SQ_LD: state_next = S_POW_SQ_MUL;
      S_POW_SQ_MUL: begin
        if (flags.mul_last) state_next = S_POW_SQ_WB;
      end
      S_POW_SQ_WB: state_next = S_POW_CHECK;
      S_POW_WB: state_next = S_DONE;
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = CMD_NONE;
    in_ready  = 1'b0;
    res_valid = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd = CMD_LOAD;
      end
      S_DISPATCH:    cmd = CMD_DISPATCH;
      S_MUL:         cmd = CMD_MUL_STEP;
      S_MUL_WB:      cmd = CMD_MUL_WB;
      S_DIV:         cmd = CMD_DIV_STEP;
      S_DIV_WB:      cmd = CMD_DIV_WB;
      S_POW_CHECK:   cmd = CMD_NONE;
      S_POW_ACC_LD:  cmd = CMD_POW_LD_ACC;
      S_POW_ACC_MUL: cmd = CMD_MUL_STEP;
      S_POW_ACC_WB:  cmd = CMD_POW_WB_ACC;
      S_POW_SQ_LD:   cmd = CMD_POW_LD_SQ;
      S_POW_SQ_MUL:  cmd = CMD_MUL_STEP;
      S_POW_SQ_WB:   cmd = CMD_POW_WB_SQ;
      S_POW_WB:      cmd = CMD_POW_WB;
      S_DONE:        res_valid = 1'b1;
      default:       cmd = CMD_NONE;
    endcase
  end

endmodule

>>> tb/alu_result_checker.sv
`timescale 1ns / 100ps
// Result predictor and stream checker for the iterative integer ALU.
module alu_result_checker #(
  parameter int DATA_WIDTH = iia_pkg::DATA_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  input  logic                                s_tready,
  // operand_a, operand_b, zero padding
  input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]   s_tdata,
  // req_type
  input  logic [iia_pkg::REQ_W-1:0]           s_tuser,
  input  logic                                m_tvalid,
  input  logic                                m_tready,
  // result_value, remainder_value, zero padding
  input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]   m_tdata,
  // status_code
  input  logic [iia_pkg::ST_W-1:0]            m_tuser,
  output int                                  mismatches,
  output int                                  in_flight
);
  import iia_pkg::*;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] value;
    logic [DATA_WIDTH-1:0] remainder;
    logic [ST_W-1:0]       status;
  } alu_result_t;

  alu_result_t expected_results[$];
  int errors = 0;

  function automatic alu_result_t compute_alu_result(input logic [REQ_W-1:0] op,
                                                     input logic [DATA_WIDTH-1:0] a,
                                                     input logic [DATA_WIDTH-1:0] b);
    alu_result_t r;
    logic [DATA_WIDTH-1:0] acc;
    logic [DATA_WIDTH-1:0] sq;
    logic [DATA_WIDTH-1:0] expo;
    r = '0;
    case (op)
      OP_ADD: r.value = a + b;
      OP_SUB: r.value = a - b;
      OP_MUL: begin
        // a count of zero or below gives nothing
        if (b != '0 && !b[DATA_WIDTH-1]) r.value = a * b;
      end
      OP_DIV: begin
        if (b == '0) r.status = ST_DIV_ZERO;
        else if (b[DATA_WIDTH-1]) r.status = ST_NEG_DIV;
        else if (a[DATA_WIDTH-1]) r.remainder = a;
        else begin
          r.value = a / b;
          r.remainder = a % b;
        end
      end
      OP_POW: begin
        if (b == '0) r.value = (a == '0) ? '0 : DATA_WIDTH'(1);
        else if (b[DATA_WIDTH-1]) r.value = a;
        else if (a != '0) begin
          acc = DATA_WIDTH'(1);
          sq = a;
          expo = b;
          while (expo != '0) begin
            if (expo[0]) acc = acc * sq;
            sq = sq * sq;
            expo = expo >> 1;
          end
          r.value = acc;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : watch
    alu_result_t head;
    alu_result_t seen;
    if (!rst) begin
      // retire the older expectation before queueing one accepted on the same edge
      if (m_tvalid && m_tready) begin
        seen.value = m_tdata[DATA_WIDTH-1:0];
        seen.remainder = m_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
        seen.status = m_tuser;
        if (expected_results.size() == 0) begin
          $error("result word with no request outstanding");
          errors++;
        end else begin
          head = expected_results.pop_front();
          if (head.value !== seen.value) begin
            $error("result_value: expected %0d, got %0d",
                   $signed(head.value), $signed(seen.value));
            errors++;
          end
          if (head.remainder !== seen.remainder) begin
            $error("remainder_value: expected %0d, got %0d",
                   $signed(head.remainder), $signed(seen.remainder));
            errors++;
          end
          if (head.status !== seen.status) begin
            $error("status_code: expected %0d, got %0d", head.status, seen.status);
            errors++;
          end
        end
      end
      if (s_tvalid && s_tready)
        expected_results.push_back(compute_alu_result(s_tuser, s_tdata[DATA_WIDTH-1:0],
                                                      s_tdata[2*DATA_WIDTH-1:DATA_WIDTH]));
    end
    mismatches <= errors;
    in_flight <= expected_results.size();
  end

endmodule

>>> tb/iterative_integer_alu_test.sv
`timescale 1ns / 100ps
// Stimulus, handshake pacing and verdict for the iterative integer ALU.
module iterative_integer_alu_test;
  import iia_pkg::*;

  localparam int     W            = DATA_WIDTH_DEF;
  localparam int     TDATA_W      = ((2*W+7)/8)*8;
  localparam int     RANDOM_WORDS = 1400;
  localparam int     MAX_GAP      = 14;
  localparam int     DRAIN_CYCLES = 64;
  // worst case: every word a full-length power behind both longest stalls, four times over
  localparam longint CYCLE_LIMIT  = 12_500_000;

  localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [TDATA_W-1:0] s_tdata = '0;
  logic [REQ_W-1:0]   s_tuser = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;
  logic [ST_W-1:0]    m_tuser;

  int     mismatches;
  int     in_flight;
  longint cycles = 0;
  bit     send_burst = 1'b0;
  bit     take_burst = 1'b0;

  always #5ns clk = ~clk;

  iterative_integer_alu #(.DATA_WIDTH(W)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  alu_result_checker #(.DATA_WIDTH(W)) u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .mismatches(mismatches), .in_flight(in_flight)
  );

  function automatic logic [W-1:0] draw_operand();
    case ($urandom_range(0, 7))
      0: return W'(int'($urandom_range(0, 40)) - 20);
      1: return MOST_NEG;
      2: return MOST_POS;
      3: return '0;
      4: return '1;
      default: return W'({$urandom, $urandom});
    endcase
  endfunction

  function automatic logic [W-1:0] draw_divisor();
    if ($urandom_range(0, 2) == 0) return W'($urandom_range(1, 100));
    return draw_operand();
  endfunction

  // keep most exponents short: a full-width exponent runs the longest power loop
  function automatic logic [W-1:0] draw_exponent();
    case ($urandom_range(0, 19))
      0: return draw_operand();
      1: return W'(-int'($urandom_range(1, 1000)));
      default: return W'($urandom_range(0, 300));
    endcase
  endfunction

  // called at a falling edge; returns at the falling edge after the word is taken
  task automatic send_word(input logic [REQ_W-1:0] op, input logic [W-1:0] a,
                           input logic [W-1:0] b);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= TDATA_W'({b, a});
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // hold off until every outstanding result has come back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (in_flight != 0);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : result_sink
    int gap;
    int taken;
    taken = 0;
    wait (!rst);
    @(negedge clk);
    m_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        taken++;
        if (taken % 64 == 0) take_burst = ($urandom_range(0, 3) == 0);
        gap = take_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
          @(negedge clk);
          m_tready <= 1'b0;
          repeat (gap) @(negedge clk);
          m_tready <= 1'b1;
        end
      end
    end
  end

  initial begin : stimulus
    logic [REQ_W-1:0] op;
    logic [W-1:0]     a;
    logic [W-1:0]     b;
    int               pick;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // wrap-around on add and subtract
    send_word(OP_ADD, MOST_POS, W'(1));
    send_word(OP_ADD, MOST_NEG, '1);
    send_word(OP_SUB, MOST_NEG, W'(1));
    send_word(OP_SUB, '0, MOST_NEG);
    // multiply: zero count, negative count, longest count, negative multiplicand
    send_word(OP_MUL, W'(1234), '0);
    send_word(OP_MUL, W'(1234), W'(-5));
    send_word(OP_MUL, MOST_POS, MOST_POS);
    send_word(OP_MUL, W'(-3), W'(7));
    // divide: zero divisor, negative divisor, negative dividend, ordinary cases
    send_word(OP_DIV, W'(55), '0);
    send_word(OP_DIV, MOST_NEG, '1);
    send_word(OP_DIV, W'(-17), W'(5));
    send_word(OP_DIV, W'(100), W'(7));
    send_word(OP_DIV, MOST_POS, W'(1));
    send_word(OP_DIV, W'(5), W'(9));
    // power: zero to the zeroth, zero exponent, zero base, negative exponent,
    // negative base, wrap past the top bit, longest exponent
    send_word(OP_POW, '0, '0);
    send_word(OP_POW, W'(9), '0);
    send_word(OP_POW, '0, W'(5));
    send_word(OP_POW, W'(7), W'(-2));
    send_word(OP_POW, W'(-3), W'(5));
    send_word(OP_POW, W'(2), W'(33));
    send_word(OP_POW, W'(3), MOST_POS);
    for (int c = OP_POW + 1; c < (1 << REQ_W); c++)
      send_word(REQ_W'(c), draw_operand(), draw_operand());
    drain_results();

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 64 == 0) send_burst = ($urandom_range(0, 3) == 0);
      if (n == RANDOM_WORDS / 2) drain_results();
      pick = $urandom_range(0, 99);
      a = draw_operand();
      b = draw_operand();
      if (pick < 18) op = OP_ADD;
      else if (pick < 36) op = OP_SUB;
      else if (pick < 56) op = OP_MUL;
      else if (pick < 78) begin
        op = OP_DIV;
        b = draw_divisor();
      end else if (pick < 95) begin
        op = OP_POW;
        b = draw_exponent();
      end else op = REQ_W'($urandom_range(OP_POW + 1, (1 << REQ_W) - 1));
      send_word(op, a, b);
    end
    s_tvalid <= 1'b0;

    while (in_flight != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && in_flight == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
